### sv/position_crc_tracker_unit_assert.svh
// Assertion macros used by the top level of the position CRC tracker.
`ifndef POSITION_CRC_TRACKER_UNIT_ASSERT_SVH
`define POSITION_CRC_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pct assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pct assertion failed");

`endif

### sv/pct_pkg.sv
// Shared types, constants and the CRC byte function of the position CRC tracker.
package pct_pkg;

   localparam logic [1:0] OP_MOVE  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'hAB;   // 0xD5 reflected

   localparam int RecBytes = 20;
   localparam int CntBits  = $clog2(RecBytes);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_CRC,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic crc_step;
      logic push;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_move;
      logic last_byte;
      logic out_free;
   } ctrl_status_type;

   // One reflected CRC-8 byte update, eight shift steps.
   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

### sv/pct_controller.sv
// Control state machine of the position CRC tracker.
module pct_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pct_pkg::ctrl_status_type status,
   output pct_pkg::ctrl_cmd_type    cmd
);

   pct_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pct_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         pct_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = pct_pkg::ST_UPDATE;
            end
         end
         pct_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.is_move ? pct_pkg::ST_CRC : pct_pkg::ST_PUSH;
         end
         pct_pkg::ST_CRC: begin
            cmd.crc_step = 1'b1;
            if (status.last_byte) state_in = pct_pkg::ST_PUSH;
         end
         pct_pkg::ST_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = pct_pkg::ST_IDLE;
            end
         end
         default: state_in = pct_pkg::ST_IDLE;
      endcase
   end

endmodule

### sv/pct_datapath.sv
// Position registers, record shifter, byte-serial CRC and result register.
module pct_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  pct_pkg::ctrl_cmd_type    cmd,
   output pct_pkg::ctrl_status_type status,
   input  logic [1:0]               req_opcode,
   input  logic signed [31:0]       req_value_x,
   input  logic signed [31:0]       req_value_y,
   input  logic signed [31:0]       req_value_z,
   input  logic signed [31:0]       req_move_duration,
   input  logic [31:0]              req_command_flags,
   input  logic                     req_skip_check,
   input  logic                     req_machine_fault,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_crc_match,
   output logic [7:0]               rsp_computed_crc,
   output logic                     rsp_accepted,
   output logic signed [31:0]       rsp_out_x,
   output logic signed [31:0]       rsp_out_y,
   output logic signed [31:0]       rsp_out_z
);

   localparam int RecBits = 8 * pct_pkg::RecBytes;

   // captured transaction
   logic [1:0]         op_ff;
   logic signed [31:0] vx_ff, vy_ff, vz_ff, dur_ff;
   logic [31:0]        flags_ff;
   logic               skip_ff, fault_ff;

   // running position
   logic signed [31:0] track_x_ff, track_y_ff, track_z_ff;
   logic signed [31:0] sum_x, sum_y, sum_z;

   logic [RecBits-1:0]          rec_ff;
   logic [7:0]                  crc_ff;
   logic [pct_pkg::CntBits-1:0] cnt_ff;

   logic                        out_valid_ff, out_valid_in;
   logic                        out_match_ff, out_acc_ff;
   logic [7:0]                  out_crc_ff;
   logic signed [31:0]          out_x_ff, out_y_ff, out_z_ff;

   logic is_move, match;

   assign is_move = (op_ff == pct_pkg::OP_MOVE);
   assign match   = (crc_ff == flags_ff[7:0]);

   assign sum_x = track_x_ff + vx_ff;
   assign sum_y = track_y_ff + vy_ff;
   assign sum_z = track_z_ff + vz_ff;

   assign status.is_move   = is_move;
   assign status.last_byte = (cnt_ff == pct_pkg::CntBits'(pct_pkg::RecBytes - 1));
   assign status.out_free  = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         vx_ff    <= req_value_x;
         vy_ff    <= req_value_y;
         vz_ff    <= req_value_z;
         dur_ff   <= req_move_duration;
         flags_ff <= req_command_flags;
         skip_ff  <= req_skip_check;
         fault_ff <= req_machine_fault;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_x_ff <= '0;
         track_y_ff <= '0;
         track_z_ff <= '0;
      end else if (cmd.update) begin
         case (op_ff)
            pct_pkg::OP_MOVE: begin
               track_x_ff <= sum_x;
               track_y_ff <= sum_y;
               track_z_ff <= sum_z;
            end
            pct_pkg::OP_CLEAR: begin
               track_x_ff <= '0;
               track_y_ff <= '0;
               track_z_ff <= '0;
            end
            pct_pkg::OP_LOAD: begin
               track_x_ff <= vx_ff;
               track_y_ff <= vy_ff;
               track_z_ff <= vz_ff;
            end
            default: ;  // unused opcode keeps the position
         endcase
      end
   end

   // Record bytes leave the low end, little-endian X, Y, Z, duration, flags.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rec_ff <= {flags_ff[31:8], 8'h00, dur_ff, sum_z, sum_y, sum_x};
         crc_ff <= pct_pkg::CRC_INIT;
         cnt_ff <= '0;
      end else if (cmd.crc_step) begin
         rec_ff <= rec_ff >> 8;
         crc_ff <= pct_pkg::crc_byte(crc_ff, rec_ff[7:0]);
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.push)                    out_valid_in = 1'b1;
      else if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_match_ff <= is_move && match;
         out_crc_ff   <= is_move ? crc_ff : 8'h00;
         out_acc_ff   <= is_move && (match || skip_ff) && !fault_ff;
         out_x_ff     <= track_x_ff;
         out_y_ff     <= track_y_ff;
         out_z_ff     <= track_z_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_crc_match    = out_match_ff;
   assign rsp_computed_crc = out_crc_ff;
   assign rsp_accepted     = out_acc_ff;
   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_out_z        = out_z_ff;

endmodule

### sv/position_crc_tracker_unit.sv
// Top level of the position CRC tracker: controller plus datapath.
//
// Usage:
//  - Request channel (req_*): one motion transaction per handshake, taken at
//    a rising edge with req_valid high and req_stall low. Opcode move adds
//    the deltas to the stored X/Y/Z, clear zeroes it, load sets it.
//  - Response channel (rsp_*): one transaction per request, in order, with
//    the CRC-8 of the new position record for a move (zero otherwise), the
//    match flag, the accept flag and the position after the request.
//  - Sequence: after acceptance a move passes the update state, the CRC
//    state at one record byte per cycle over the 20-byte record, and the
//    push; clear, load and the unused opcode skip the CRC state.
//  - In flight: one transaction at a time; the next request can be taken
//    in the cycle after the result lands in the output register.
//  - Stall: a pending result waits in the output register while a new
//    request may already be taken and worked on; the push of that next
//    result waits until the output register is free.
//  - Reset (synchronous, active high): position cleared to zero, no
//    response pending, the block ready for a request.
module position_crc_tracker_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_value_x,
   input  logic signed [31:0] req_value_y,
   input  logic signed [31:0] req_value_z,
   input  logic signed [31:0] req_move_duration,
   input  logic [31:0]        req_command_flags,
   input  logic               req_skip_check,
   input  logic               req_machine_fault,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_crc_match,
   output logic [7:0]         rsp_computed_crc,
   output logic               rsp_accepted,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z
);

`include "position_crc_tracker_unit_assert.svh"

   pct_pkg::ctrl_cmd_type    cmd;
   pct_pkg::ctrl_status_type status;

   // sequencing: capture, update, 20 CRC byte steps for a move, push
   pct_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // position state, record shifter, CRC and output register
   pct_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_value_x       (req_value_x),
      .req_value_y       (req_value_y),
      .req_value_z       (req_value_z),
      .req_move_duration (req_move_duration),
      .req_command_flags (req_command_flags),
      .req_skip_check    (req_skip_check),
      .req_machine_fault (req_machine_fault),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_crc_match     (rsp_crc_match),
      .rsp_computed_crc  (rsp_computed_crc),
      .rsp_accepted      (rsp_accepted),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z)
   );

   // A result is never pushed over one the receiver has not taken.
   `PCT_ASSERT_NOW(a_push_free, clock, reset, cmd.push, !rsp_valid || !rsp_stall)
   // An accepted transaction makes the block busy on the next cycle.
   `PCT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // Clear, load and the unused opcode skip the CRC pass.
   `PCT_ASSERT_NEXT(a_no_crc_non_move, clock, reset, cmd.update && !status.is_move,
                    !cmd.crc_step)

endmodule

### verif/position_crc_tracker_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the position CRC tracker: directed and random motion streams.
module position_crc_tracker_unit_tb;

   // Opcode three has no name in the package; the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int IdleLimit   = 2000;  // cycles with no transaction on either side
   localparam int SettleCycles = 30;   // longer than a move takes from acceptance to response
   localparam int MaxPrinted  = 100;   // keep a broken run's log readable

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic signed [31:0] value_z;
      logic signed [31:0] duration;
      logic [31:0]        flags;
      logic               skip_check;
      logic               machine_fault;
   } motion_cmd_type;

   typedef struct packed {
      logic               crc_match;
      logic [7:0]         computed_crc;
      logic               accepted;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } track_result_type;

   typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = pct_pkg::OP_MOVE;
   logic signed [31:0] req_value_x = '0;
   logic signed [31:0] req_value_y = '0;
   logic signed [31:0] req_value_z = '0;
   logic signed [31:0] req_move_duration = '0;
   logic [31:0]        req_command_flags = '0;
   logic               req_skip_check = 1'b0;
   logic               req_machine_fault = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_crc_match;
   logic [7:0]         rsp_computed_crc;
   logic               rsp_accepted;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;

   position_crc_tracker_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_value_x       (req_value_x),
      .req_value_y       (req_value_y),
      .req_value_z       (req_value_z),
      .req_move_duration (req_move_duration),
      .req_command_flags (req_command_flags),
      .req_skip_check    (req_skip_check),
      .req_machine_fault (req_machine_fault),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_crc_match     (rsp_crc_match),
      .rsp_computed_crc  (rsp_computed_crc),
      .rsp_accepted      (rsp_accepted),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z)
   );

   always #5 clock = ~clock;

   // Position as the block should hold it after every accepted transaction.
   logic signed [31:0] pos_x = '0;
   logic signed [31:0] pos_y = '0;
   logic signed [31:0] pos_z = '0;

   // Responses owed by the block, oldest first.
   track_result_type due_results[$];

   int fail_count = 0;
   int n_checked  = 0;
   int n_moves    = 0;
   int n_matched  = 0;
   int n_accepted = 0;
   int n_loads    = 0;
   int n_clears   = 0;
   int n_ignored  = 0;
   int burst_left = 0;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Reflected CRC-8, fed one bit at a time, LSB first. Feeding a 32-bit word
   // this way is the same as feeding its four bytes in little-endian order.
   function automatic logic [7:0] crc8_word(input logic [7:0] crc, input logic [31:0] w);
      logic fb;
      for (int i = 0; i < 32; i++) begin
         fb  = crc[0] ^ w[i];
         crc = crc >> 1;
         if (fb) crc = crc ^ pct_pkg::CRC_POLY;
      end
      return crc;
   endfunction

   // CRC of the 20-byte record; the flags go in with their CRC byte cleared.
   function automatic logic [7:0] record_crc8(input logic [31:0] x, y, z, dur, flags);
      logic [7:0] crc;
      crc = crc8_word(pct_pkg::CRC_INIT, x);
      crc = crc8_word(crc, y);
      crc = crc8_word(crc, z);
      crc = crc8_word(crc, dur);
      return crc8_word(crc, flags & 32'hFFFF_FF00);
   endfunction

   // Moves the tracked position by one command and returns the response it owes.
   function automatic track_result_type apply_command(input motion_cmd_type c);
      track_result_type r;
      r = '0;
      case (c.opcode)
         pct_pkg::OP_MOVE: begin
            // a rejected move still moves the position: the sender tracks it too
            pos_x = pos_x + c.value_x;
            pos_y = pos_y + c.value_y;
            pos_z = pos_z + c.value_z;
            r.computed_crc = record_crc8(pos_x, pos_y, pos_z, c.duration, c.flags);
            r.crc_match    = (r.computed_crc == c.flags[7:0]);
            r.accepted     = (r.crc_match || c.skip_check) && !c.machine_fault;
            n_moves++;
            if (r.crc_match) n_matched++;
            if (r.accepted) n_accepted++;
         end
         pct_pkg::OP_CLEAR: begin
            pos_x = '0;
            pos_y = '0;
            pos_z = '0;
            n_clears++;
         end
         pct_pkg::OP_LOAD: begin
            pos_x = c.value_x;
            pos_y = c.value_y;
            pos_z = c.value_z;
            n_loads++;
         end
         default: n_ignored++;
      endcase
      r.out_x = pos_x;
      r.out_y = pos_y;
      r.out_z = pos_z;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h7FFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   // Small steps half the time, as real moves are, with full-range and edge values mixed in.
   function automatic logic [31:0] pick_delta();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 10) return $urandom_range(0, 4000) - 2000;
      if (pick < 17) return $urandom;
      return pick_extreme();
   endfunction

   function automatic logic [31:0] pick_word();
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, 100000);
      return $urandom;
   endfunction

   // Builds a move whose CRC byte is right for the position it leads to, or
   // off by one bit when good is low. Must be called with every earlier
   // transaction already accepted, so that the tracked position is current.
   function automatic motion_cmd_type make_move(input logic [31:0] dx, dy, dz, dur, flags_hi,
                                                input logic skip, fault, good);
      motion_cmd_type c;
      logic [7:0]     crc;
      c.opcode        = pct_pkg::OP_MOVE;
      c.value_x       = dx;
      c.value_y       = dy;
      c.value_z       = dz;
      c.duration      = dur;
      c.skip_check    = skip;
      c.machine_fault = fault;
      crc = record_crc8(pos_x + dx, pos_y + dy, pos_z + dz, dur, flags_hi);
      c.flags = {flags_hi[31:8], good ? crc : crc ^ (8'd1 << $urandom_range(0, 7))};
      return c;
   endfunction

   // Clear, load or unused opcode; the fields a move would use carry noise.
   function automatic motion_cmd_type make_other(input logic [1:0] op,
                                                 input logic [31:0] x, y, z);
      motion_cmd_type c;
      c.opcode        = op;
      c.value_x       = x;
      c.value_y       = y;
      c.value_z       = z;
      c.duration      = $urandom;
      c.flags         = $urandom;
      c.skip_check    = 1'($urandom_range(0, 1));
      c.machine_fault = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // Offers one transaction, waits for it to be taken, records the response it
   // owes, then paces the sender: bursts of back-to-back transactions with
   // random gaps between them. Always entered and left at a rising edge.
   task automatic send_command(input motion_cmd_type c);
      req_opcode        <= c.opcode;
      req_value_x       <= c.value_x;
      req_value_y       <= c.value_y;
      req_value_z       <= c.value_z;
      req_move_duration <= c.duration;
      req_command_flags <= c.flags;
      req_skip_check    <= c.skip_check;
      req_machine_fault <= c.machine_fault;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall);
      due_results.push_back(apply_command(c));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = $urandom_range(0, 40);
      end
   endtask

   // Holds the sender off until every owed response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Field extremes, every opcode, wraparound, and the skip/fault corners.
   task automatic test_directed_cases();
      send_command(make_other(pct_pkg::OP_CLEAR, $urandom, $urandom, $urandom));
      send_command(make_move(0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b1));
      send_command(make_other(pct_pkg::OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'hFFFF_FFFF));
      // each axis crosses a wrap point
      send_command(make_move(1, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 32'hFFFF_FF00,
                             1'b0, 1'b0, 1'b1));
      // bad CRC let through by skip
      send_command(make_move(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'hFFFF_FF00, 1'b1, 1'b0, 1'b0));
      // bad CRC rejected, position still moves
      send_command(make_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                             32'hA5A5_A500, 1'b0, 1'b0, 1'b0));
      // machine fault overrides a good CRC and a skip
      send_command(make_move(100, -200, 300, 1000, 32'h1234_5600, 1'b0, 1'b1, 1'b1));
      send_command(make_move(-5, 5, -5, 0, 32'h0F0F_0F00, 1'b1, 1'b1, 1'b0));
      send_command(make_move(7, 7, 7, 1, 32'hF0F0_F000, 1'b1, 1'b1, 1'b1));
      // unused opcode: position kept
      send_command(make_other(OP_UNUSED, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h1357_9BDF));
      send_command(make_other(pct_pkg::OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF));
      send_command(make_move(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                             32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1));
      send_command(make_other(pct_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'h8000_0000,
                              32'h7FFF_FFFF));
      // positive overflow into negative
      send_command(make_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                             1'b0, 1'b0, 1'b1));
      send_command(make_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                             1'b0, 1'b0, 1'b1));
      send_command(make_other(pct_pkg::OP_LOAD, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000));
      // negative underflow into the largest positive value
      send_command(make_move(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 1'b0, 1'b0, 1'b1));
      send_command(make_other(OP_UNUSED, 0, 0, 0));
      send_command(make_move(0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b1));
   endtask

   // Mostly well-formed traffic: moves carrying the right CRC for the
   // position the sender tracks, with the occasional load, clear, unused opcode or bad move.
   task automatic test_tracked_stream(input int count);
      motion_cmd_type c;
      int             pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            c = make_move(pick_delta(), pick_delta(), pick_delta(), pick_word(), $urandom,
                          $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, 1'b1);
         end else if (pick < 86) begin
            c = make_move(pick_delta(), pick_delta(), pick_delta(), pick_word(), $urandom,
                          1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 1'b0);
         end else if (pick < 92) begin
            c = make_other(pct_pkg::OP_LOAD, pick_delta(), pick_delta(), pick_delta());
         end else if (pick < 95) begin
            c = make_other(pct_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
         end else if (pick < 97) begin
            c = make_other(OP_UNUSED, $urandom, $urandom, $urandom);
         end else begin
            c = make_move(pick_delta(), pick_delta(), pick_delta(), $urandom, 0,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
            c.flags = $urandom;
         end
         send_command(c);
      end
   endtask

   // The sender goes quiet until the block has answered everything, then
   // restarts from a known position.
   task automatic test_drain_pause();
      repeat (5) send_command(make_move(pick_delta(), pick_delta(), pick_delta(), pick_word(),
                                        $urandom, 1'b0, 1'b0, 1'b1));
      drain_responses();
      send_command(make_other(pct_pkg::OP_LOAD, $urandom, $urandom, $urandom));
      send_command(make_move(pick_delta(), pick_delta(), pick_delta(), pick_word(),
                             $urandom, 1'b0, 1'b0, 1'b1));
      drain_responses();
      send_command(make_other(pct_pkg::OP_CLEAR, $urandom, $urandom, $urandom));
   endtask

   // Heavier share of broken moves, raw flag words and unused opcodes.
   task automatic test_noisy_stream(input int count);
      motion_cmd_type c;
      int             pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         c = make_move(pick_delta(), pick_delta(), pick_delta(), $urandom, $urandom,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick < 40);
         if (pick >= 60 && pick < 75) c.flags = $urandom;
         else if (pick >= 75 && pick < 85) c = make_other(OP_UNUSED, $urandom, $urandom,
                                                          $urandom);
         else if (pick >= 85 && pick < 95) c = make_other(pct_pkg::OP_LOAD, $urandom,
                                                          $urandom, $urandom);
         else if (pick >= 95) c = make_other(pct_pkg::OP_CLEAR, $urandom, $urandom,
                                             $urandom);
         send_command(c);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string field, input logic [31:0] want, got);
      fail_count++;
      if (fail_count <= MaxPrinted)
         $display("mismatch: %s on response %0d, expected %h, got %h",
                  field, n_checked, want, got);
   endtask

   // Receiver stall: switches among open, light, heavy and periodic patterns
   // at random intervals, so stalls land on every phase of a move.
   rx_pattern_type rx_pattern = RX_OPEN;
   int             rx_hold = 0;
   int             rx_phase = 0;

   always @(posedge clock) begin
      if (rx_hold == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         rx_hold    = $urandom_range(50, 400);
      end else begin
         rx_hold--;
      end
      rx_phase++;
      case (rx_pattern)
         RX_OPEN:  rsp_stall <= 1'b0;
         RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:  rsp_stall <= (rx_phase % 37) < 15;
      endcase
   end

   // Each response taken is checked field by field against the oldest owed one.
   always @(posedge clock) begin
      track_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            report_mismatch("response with none owed, out_x", 'x, rsp_out_x);
         end else begin
            want = due_results.pop_front();
            if (rsp_crc_match !== want.crc_match)
               report_mismatch("crc_match", want.crc_match, rsp_crc_match);
            if (rsp_computed_crc !== want.computed_crc)
               report_mismatch("computed_crc", want.computed_crc, rsp_computed_crc);
            if (rsp_accepted !== want.accepted)
               report_mismatch("accepted", want.accepted, rsp_accepted);
            if (rsp_out_x !== want.out_x) report_mismatch("out_x", want.out_x, rsp_out_x);
            if (rsp_out_y !== want.out_y) report_mismatch("out_y", want.out_y, rsp_out_y);
            if (rsp_out_z !== want.out_z) report_mismatch("out_z", want.out_z, rsp_out_z);
         end
         n_checked++;
      end
   end

   // Watchdog: too long with no transaction on either channel ends the run.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("watchdog: no transaction for %0d cycles, %0d responses owed",
                  IdleLimit, due_results.size());
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Run
   // ------------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_tracked_stream(800);
      test_drain_pause();
      test_tracked_stream(600);
      test_noisy_stream(300);

      // let the last responses out, then watch a little longer for strays
      drain_responses();
      repeat (SettleCycles) @(posedge clock);

      $display("covered %0d moves (%0d good CRC, %0d accepted), %0d loads, %0d clears, %0d other",
               n_moves, n_matched, n_accepted, n_loads, n_clears, n_ignored);
      $display("%0d responses checked, %0d field mismatches", n_checked, fail_count);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/pct_pkg.sv
sv/pct_controller.sv
sv/pct_datapath.sv
sv/position_crc_tracker_unit.sv
verif/position_crc_tracker_unit_tb.sv
